>>> rtl/core/free_space_map_first_fit_unit_defines.svh
// ----------------------------------------------------------------------------
// Free-space map assertion macros
// Shared assertion forms for the free-space map blocks.
// ----------------------------------------------------------------------------
`ifndef FREE_SPACE_MAP_FIRST_FIT_UNIT_DEFINES_SVH
`define FREE_SPACE_MAP_FIRST_FIT_UNIT_DEFINES_SVH

// check on every clock edge outside reset
`define FSMAP_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define FSMAP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/fsmap_pkg.sv
// ----------------------------------------------------------------------------
// Free-space map package
// Widths, codes, types and helper functions of the free-space map.
// ----------------------------------------------------------------------------
package fsmap_pkg;

  localparam int PAGE_W    = 12;
  localparam int CLASS_W   = 4;
  localparam int LANE_W    = 4;
  localparam int LANES     = 1 << LANE_W;
  localparam int ROW_W     = PAGE_W - LANE_W;
  localparam int ROWS      = 1 << ROW_W;
  localparam int CNT_W     = PAGE_W + 1;
  localparam int BYTES_W   = 16;
  localparam int SHIFT_W   = 4;
  localparam int THR_W     = CLASS_W + 1;

  localparam logic [CLASS_W-1:0] CLASS_MAX   = 4'hF;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd8;
  localparam logic [THR_W-1:0]   THR_NONE    = 5'd16;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_FIND   = 1'b1;

  typedef logic [LANES-1:0][CLASS_W-1:0] row_word_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD_WR,
    S_HINT,
    S_SCAN
  } seq_state_t;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [ROW_W-1:0] addr;
    row_word_t        wdata;
  } ram_cmd_t;

  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic [LANES-1:0] lane_en;
  } match_req_t;

  typedef struct packed {
    logic              hit;
    logic [LANE_W-1:0] lane;
  } match_rsp_t;

  // class stored for a byte count: bytes >> shift, saturated
  function automatic logic [CLASS_W-1:0] calc_cls(input logic [BYTES_W-1:0] bytes,
                                                  input logic [SHIFT_W-1:0] shift);
    logic [BYTES_W-1:0] q;
    q = bytes >> shift;
    calc_cls = (q > BYTES_W'(CLASS_MAX)) ? CLASS_MAX : q[CLASS_W-1:0];
  endfunction

  // smallest class that covers a request: ceil(bytes / 2^shift), 16 if none
  function automatic logic [THR_W-1:0] calc_thr(input logic [BYTES_W-1:0] bytes,
                                                input logic [SHIFT_W-1:0] shift);
    logic [BYTES_W-1:0] q;
    logic [BYTES_W-1:0] low_mask;
    logic               rem;
    q        = bytes >> shift;
    low_mask = ~({BYTES_W{1'b1}} << shift);
    rem      = (bytes & low_mask) != '0;
    if (q > BYTES_W'(CLASS_MAX)) begin
      calc_thr = THR_NONE;
    end else begin
      calc_thr = q[THR_W-1:0] + THR_W'(rem);
    end
  endfunction

endpackage

>>> rtl/core/fsmap_class_ram.sv
// ----------------------------------------------------------------------------
// Free-space class memory
// Rows of sixteen 4-bit classes, one write and one registered read per cycle.
// A row never written since reset reads as all zero.
// ----------------------------------------------------------------------------
module fsmap_class_ram
  import fsmap_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ram_cmd_t  cmd,
  output row_word_t rd_word
);

  row_word_t       mem [ROWS];
  logic [ROWS-1:0] row_valid;
  row_word_t       rd_q;
  logic            rd_valid_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        row_valid[cmd.addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid_q <= row_valid[cmd.addr];
      end
    end
  end

  assign rd_word = rd_valid_q ? rd_q : '0;

endmodule

>>> rtl/core/fsmap_match.sv
// ----------------------------------------------------------------------------
// Class match unit
// Compares one memory row against the class threshold and returns the
// lowest enabled lane that fits.
// ----------------------------------------------------------------------------
module fsmap_match
  import fsmap_pkg::*;
(
  input  row_word_t  word,
  input  match_req_t req,
  output match_rsp_t rsp
);

  logic [LANES-1:0] fit;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      fit[i] = req.lane_en[i] && ({1'b0, word[i]} >= req.thr);
    end
  end

  always_comb begin
    rsp.hit  = |fit;
    rsp.lane = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (fit[i]) begin
        rsp.lane = LANE_W'(i);
      end
    end
  end

endmodule

>>> rtl/core/fsmap_seq.sv
// ----------------------------------------------------------------------------
// Free-space map sequencer
// Runs updates as read-modify-write, tries the hint, then scans rows
// through the match unit, keeps tracked count, hint and step register.
// ----------------------------------------------------------------------------
`include "free_space_map_first_fit_unit_defines.svh"

module fsmap_seq
  import fsmap_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               req_type,
  input  logic [PAGE_W-1:0]  page_id,
  input  logic [BYTES_W-1:0] space_bytes,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_data,
  output logic               busy,
  output logic               done,
  output logic               found,
  output logic [PAGE_W-1:0]  result_page,
  output ram_cmd_t           ram_cmd,
  input  row_word_t          rd_word,
  output match_req_t         match_req,
  input  match_rsp_t         match_rsp
);

  seq_state_t         state, state_next;
  logic [SHIFT_W-1:0] unit_shift, unit_shift_next;
  logic [CNT_W-1:0]   tracked_count, tracked_count_next;
  logic               hint_valid, hint_valid_next;
  logic [PAGE_W-1:0]  hint_page, hint_page_next;
  logic [PAGE_W-1:0]  req_page, req_page_next;
  logic [THR_W-1:0]   thr, thr_next;
  logic [CLASS_W-1:0] upd_cls, upd_cls_next;
  logic               upd_nonzero, upd_nonzero_next;
  logic [ROW_W-1:0]   rd_row, rd_row_next;
  logic [ROW_W-1:0]   cmp_row, cmp_row_next;
  logic               cmp_pending, cmp_pending_next;
  logic               issued_all, issued_all_next;
  logic               done_next;
  logic               found_next;
  logic [PAGE_W-1:0]  result_page_next;

  logic [CNT_W-1:0]   tracked_m1;
  logic [ROW_W-1:0]   last_row;
  logic [LANE_W-1:0]  last_lane;
  logic [LANES-1:0]   last_mask;
  logic [CNT_W-1:0]   page_end;
  row_word_t          upd_word;

  assign tracked_m1 = tracked_count - CNT_W'(1);
  assign last_row   = tracked_m1[PAGE_W-1:LANE_W];
  assign last_lane  = tracked_m1[LANE_W-1:0];
  assign page_end   = {1'b0, req_page} + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      last_mask[i] = LANE_W'(i) <= last_lane;
    end
  end

  always_comb begin
    upd_word                      = rd_word;
    upd_word[req_page[LANE_W-1:0]] = upd_cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      unit_shift    <= SHIFT_RESET;
      tracked_count <= '0;
      hint_valid    <= 1'b0;
      hint_page     <= '0;
      cmp_pending   <= 1'b0;
      issued_all    <= 1'b0;
      done          <= 1'b0;
      found         <= 1'b0;
      result_page   <= '0;
    end else begin
      state         <= state_next;
      unit_shift    <= unit_shift_next;
      tracked_count <= tracked_count_next;
      hint_valid    <= hint_valid_next;
      hint_page     <= hint_page_next;
      cmp_pending   <= cmp_pending_next;
      issued_all    <= issued_all_next;
      done          <= done_next;
      found         <= found_next;
      result_page   <= result_page_next;
    end
  end

  always_ff @(posedge clk) begin
    req_page    <= req_page_next;
    thr         <= thr_next;
    upd_cls     <= upd_cls_next;
    upd_nonzero <= upd_nonzero_next;
    rd_row      <= rd_row_next;
    cmp_row     <= cmp_row_next;
  end

  always_comb begin
    state_next         = state;
    unit_shift_next    = cfg_we ? cfg_data : unit_shift;
    tracked_count_next = tracked_count;
    hint_valid_next    = hint_valid;
    hint_page_next     = hint_page;
    req_page_next      = req_page;
    thr_next           = thr;
    upd_cls_next       = upd_cls;
    upd_nonzero_next   = upd_nonzero;
    rd_row_next        = rd_row;
    cmp_row_next       = cmp_row;
    cmp_pending_next   = cmp_pending;
    issued_all_next    = issued_all;
    done_next          = 1'b0;
    found_next         = 1'b0;
    result_page_next   = '0;
    ram_cmd            = '0;
    match_req.thr      = thr;
    match_req.lane_en  = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          req_page_next    = page_id;
          thr_next         = calc_thr(space_bytes, unit_shift);
          upd_cls_next     = calc_cls(space_bytes, unit_shift);
          upd_nonzero_next = space_bytes != '0;
          if (req_type == REQ_UPDATE) begin
            ram_cmd.rd_en = 1'b1;
            ram_cmd.addr  = page_id[PAGE_W-1:LANE_W];
            state_next    = S_UPD_WR;
          end else if (hint_valid) begin
            ram_cmd.rd_en = 1'b1;
            ram_cmd.addr  = hint_page[PAGE_W-1:LANE_W];
            state_next    = S_HINT;
          end else if (tracked_count == '0) begin
            done_next = 1'b1;
          end else begin
            rd_row_next      = '0;
            cmp_pending_next = 1'b0;
            issued_all_next  = 1'b0;
            state_next       = S_SCAN;
          end
        end
      end

      S_UPD_WR: begin
        ram_cmd.wr_en = 1'b1;
        ram_cmd.addr  = req_page[PAGE_W-1:LANE_W];
        ram_cmd.wdata = upd_word;
        if (page_end > tracked_count) begin
          tracked_count_next = page_end;
        end
        if (upd_nonzero) begin
          if (!hint_valid || (req_page < hint_page)) begin
            hint_valid_next = 1'b1;
            hint_page_next  = req_page;
          end
        end else if (hint_valid && (hint_page == req_page)) begin
          hint_valid_next = 1'b0;
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      S_HINT: begin
        match_req.lane_en = LANES'(1) << hint_page[LANE_W-1:0];
        if (match_rsp.hit) begin
          done_next        = 1'b1;
          found_next       = 1'b1;
          result_page_next = hint_page;
          state_next       = S_IDLE;
        end else begin
          hint_valid_next = 1'b0;
          if (tracked_count == '0) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end else begin
            rd_row_next      = '0;
            cmp_pending_next = 1'b0;
            issued_all_next  = 1'b0;
            state_next       = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue the next row while the previous one is compared
        if (!issued_all) begin
          ram_cmd.rd_en    = 1'b1;
          ram_cmd.addr     = rd_row;
          rd_row_next      = rd_row + ROW_W'(1);
          cmp_row_next     = rd_row;
          cmp_pending_next = 1'b1;
          if (rd_row == last_row) begin
            issued_all_next = 1'b1;
          end
        end else begin
          cmp_pending_next = 1'b0;
        end
        if (cmp_pending) begin
          match_req.lane_en = (cmp_row == last_row) ? last_mask : '1;
          if (match_rsp.hit) begin
            done_next        = 1'b1;
            found_next       = 1'b1;
            result_page_next = {cmp_row, match_rsp.lane};
            hint_valid_next  = 1'b1;
            hint_page_next   = {cmp_row, match_rsp.lane};
            state_next       = S_IDLE;
          end else if (cmp_row == last_row) begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = state != S_IDLE;

  `FSMAP_ASSERT_CLK(a_done_idle, done |-> (state == S_IDLE), "result word outside idle")
  `FSMAP_ASSERT_CLK(a_found_done, found |-> done, "found without result strobe")
  `FSMAP_ASSERT_CLK(a_page_found, (result_page != '0) |-> found, "page given without hit")
  `FSMAP_ASSERT_CLK(a_accept_busy, (start && !busy) |=> (busy || done), "request word dropped")
  `FSMAP_ASSERT_CLK(a_scan_hint, (state == S_SCAN) |-> !hint_valid, "hint kept during scan")

endmodule

>>> rtl/core/free_space_map_first_fit_unit.sv
// ----------------------------------------------------------------------------
// Free-space map with first-fit search
// Keeps a 4-bit free-space class per page and writes classes on update; a find
// returns the hint page if it fits, else the lowest fitting tracked page.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Words
//  request   start & !busy           req_type, page_id, space_bytes
//  result    done (one cycle)        found, result_page
//  config    cfg_we                  cfg_data (unit_shift)
//
//  Update: read-modify-write of one 16-class row.
//  Find: the hint row is tried first if a hint is held; on a miss or with no
//  hint, tracked rows are scanned, one row per cycle on the class memory read
//  port. A find with nothing tracked and no hint answers without a scan.
//  Reset clears per-row valid flags at once: no clearing sweep, ready
//  right after reset. The result strobe cannot be held off.
// ----------------------------------------------------------------------------
module free_space_map_first_fit_unit
  import fsmap_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic [PAGE_W-1:0]  page_id,
  input  logic [BYTES_W-1:0] space_bytes,
  output logic               done,
  output logic               found,
  output logic [PAGE_W-1:0]  result_page,
  input  logic               cfg_we,
  input  logic [SHIFT_W-1:0] cfg_data
);

  ram_cmd_t   ram_cmd;
  row_word_t  rd_word;
  match_req_t match_req;
  match_rsp_t match_rsp;

  fsmap_class_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ram_cmd),
    .rd_word (rd_word)
  );

  fsmap_match u_match (
    .word (rd_word),
    .req  (match_req),
    .rsp  (match_rsp)
  );

  fsmap_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .req_type    (req_type),
    .page_id     (page_id),
    .space_bytes (space_bytes),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .busy        (busy),
    .done        (done),
    .found       (found),
    .result_page (result_page),
    .ram_cmd     (ram_cmd),
    .rd_word     (rd_word),
    .match_req   (match_req),
    .match_rsp   (match_rsp)
  );

endmodule

>>> tb/free_space_map_first_fit_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Free-space map first-fit testbench
// Sends page updates and first-fit finds through the start/busy handshake,
// changes the class step size between phases and checks every done word
// against a class-level model of the class store, tracked count and hint.
// ----------------------------------------------------------------------------
module free_space_map_first_fit_unit_tb;
  import fsmap_pkg::*;

  localparam int LIMIT = 3_000_000;

  typedef struct {
    logic              found;
    logic [PAGE_W-1:0] page;
  } answer_t;

  class fit_scoreboard;
    logic [CLASS_W-1:0] classes [1 << PAGE_W];
    logic [CNT_W-1:0]   tracked;
    bit                 hint_ok;
    logic [PAGE_W-1:0]  hint_pg;
    logic [SHIFT_W-1:0] shift;
    answer_t            pending [$];
    int                 errors;
    int                 finds;
    int                 hits;

    function new();
      foreach (classes[i]) classes[i] = '0;
      tracked = '0;
      hint_ok = 1'b0;
      hint_pg = '0;
      shift   = SHIFT_RESET;
      errors  = 0;
      finds   = 0;
      hits    = 0;
    endfunction

    function bit fits(logic [PAGE_W-1:0] pg, logic [BYTES_W-1:0] need);
      logic [31:0] cap;
      cap = 32'(classes[pg]) << shift;
      return 32'(need) <= cap;
    endfunction

    function void note_request(logic kind, logic [PAGE_W-1:0] pg,
                               logic [BYTES_W-1:0] bytes);
      answer_t     a;
      logic [31:0] q;
      a.found = 1'b0;
      a.page  = '0;
      if (kind == REQ_UPDATE) begin
        q = 32'(bytes) >> shift;
        classes[pg] = (q > 32'(CLASS_MAX)) ? CLASS_MAX : q[CLASS_W-1:0];
        if ({1'b0, pg} + 13'd1 > tracked) tracked = {1'b0, pg} + 13'd1;
        if (bytes != '0) begin
          if (!hint_ok || pg < hint_pg) begin
            hint_ok = 1'b1;
            hint_pg = pg;
          end
        end else if (hint_ok && hint_pg == pg) begin
          hint_ok = 1'b0;
        end
      end else begin
        finds++;
        if (hint_ok && fits(hint_pg, bytes)) begin
          a.found = 1'b1;
          a.page  = hint_pg;
        end else begin
          hint_ok = 1'b0;
          for (int i = 0; i < int'(tracked) && !a.found; i++) begin
            if (fits(PAGE_W'(i), bytes)) begin
              a.found = 1'b1;
              a.page  = PAGE_W'(i);
              hint_ok = 1'b1;
              hint_pg = PAGE_W'(i);
            end
          end
        end
        if (a.found) hits++;
      end
      pending.push_back(a);
    endfunction

    function void check_answer(logic f, logic [PAGE_W-1:0] pg);
      answer_t a;
      if (pending.size() == 0) begin
        $error("word with no request waiting: found=%0d result_page=%0d", f, pg);
        errors++;
        return;
      end
      a = pending.pop_front();
      if (f !== a.found) begin
        $error("found: expected %0d, actual %0d", a.found, f);
        errors++;
      end
      if (pg !== a.page) begin
        $error("result_page: expected %0d, actual %0d", a.page, pg);
        errors++;
      end
    endfunction
  endclass

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               start       = 1'b0;
  logic               req_type    = REQ_UPDATE;
  logic [PAGE_W-1:0]  page_id     = '0;
  logic [BYTES_W-1:0] space_bytes = '0;
  logic               cfg_we      = 1'b0;
  logic [SHIFT_W-1:0] cfg_data    = '0;
  logic               busy;
  logic               done;
  logic               found;
  logic [PAGE_W-1:0]  result_page;

  fit_scoreboard fit_sb = new();
  bit            idle_on;
  int            words_sent;
  int            settings_used;
  int            cycles;

  always #6 clk = ~clk;

  free_space_map_first_fit_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .page_id     (page_id),
    .space_bytes (space_bytes),
    .done        (done),
    .found       (found),
    .result_page (result_page),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && done) fit_sb.check_answer(found, result_page);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("free_space_map_first_fit_unit: mismatch");
      $finish;
    end
  end

  task automatic send_word(logic kind, logic [PAGE_W-1:0] pg, logic [BYTES_W-1:0] bytes);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) begin
        req_type    <= 1'($urandom);
        page_id     <= PAGE_W'($urandom);
        space_bytes <= BYTES_W'($urandom);
        @(posedge clk);
      end
    end
    start       <= 1'b1;
    req_type    <= kind;
    page_id     <= pg;
    space_bytes <= bytes;
    do @(posedge clk); while (busy !== 1'b0);
    fit_sb.note_request(kind, pg, bytes);
    words_sent++;
  endtask

  task automatic set_unit_shift(logic [SHIFT_W-1:0] v);
    start <= 1'b0;
    while (fit_sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    fit_sb.shift = v;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic random_word();
    logic               kind;
    logic [PAGE_W-1:0]  pg;
    logic [BYTES_W-1:0] b;
    int                 r;
    int                 v;
    kind = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 70) pg = PAGE_W'($urandom_range(0, 47));
    else if (r < 90) pg = PAGE_W'($urandom);
    else pg = (r < 95) ? '0 : '1;
    // aim near class boundaries at the current step size
    v = int'($urandom_range(0, 15) << fit_sb.shift) + int'($urandom_range(0, 2)) - 1;
    r = $urandom_range(0, 99);
    if (r < 15) b = '0;
    else if (r < 25) b = '1;
    else if (r < 70) b = (v < 0) ? '0 : (v > 65535) ? '1 : BYTES_W'(v);
    else b = BYTES_W'($urandom);
    send_word(kind, pg, b);
  endtask

  initial begin
    logic [SHIFT_W-1:0] phase_shift [7];
    phase_shift = '{4'd0, 4'd12, 4'd15, 4'd13, 4'd4, 4'd8, 4'd0};
    phase_shift[6] = SHIFT_W'($urandom);
    idle_on = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_unit_shift(SHIFT_RESET);
    send_word(REQ_FIND, 12'd0, 16'd0);
    send_word(REQ_FIND, 12'd0, 16'hFFFF);
    send_word(REQ_UPDATE, 12'd4095, 16'd0);
    send_word(REQ_FIND, 12'd77, 16'd0);
    send_word(REQ_UPDATE, 12'd10, 16'hFFFF);
    send_word(REQ_FIND, 12'd0, 16'd1);
    send_word(REQ_FIND, 12'd0, 16'd3840);
    send_word(REQ_FIND, 12'd0, 16'd3841);
    send_word(REQ_UPDATE, 12'd5, 16'd100);
    send_word(REQ_FIND, 12'd0, 16'd1);
    send_word(REQ_UPDATE, 12'd10, 16'd0);
    send_word(REQ_FIND, 12'd0, 16'd0);
    send_word(REQ_UPDATE, 12'd0, 16'd255);
    send_word(REQ_UPDATE, 12'd3, 16'd256);
    send_word(REQ_FIND, 12'd0, 16'd256);
    send_word(REQ_FIND, 12'd0, 16'd257);
    send_word(REQ_UPDATE, 12'd4095, 16'hFFFF);
    send_word(REQ_FIND, 12'd0, 16'hFFFF);
    send_word(REQ_FIND, 12'd0, 16'd3840);

    for (int p = 0; p < 7; p++) begin
      set_unit_shift(phase_shift[p]);
      idle_on = (p != 3);
      case (p)
        0: begin
          send_word(REQ_UPDATE, 12'd2, 16'd20);
          send_word(REQ_FIND, 12'd0, 16'd15);
        end
        1: begin
          send_word(REQ_FIND, 12'd0, 16'hF000);
          send_word(REQ_FIND, 12'd0, 16'hF001);
        end
        2: begin
          send_word(REQ_UPDATE, 12'd7, 16'hFFFF);
          send_word(REQ_FIND, 12'd0, 16'h8000);
        end
        default: ;
      endcase
      repeat (257) random_word();
    end

    start <= 1'b0;
    while (fit_sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("sent %0d words over %0d step-size settings", words_sent, settings_used);
    $display("%0d finds, %0d of them fitted a page", fit_sb.finds, fit_sb.hits);
    if (fit_sb.errors == 0 && fit_sb.pending.size() == 0) begin
      $display("free_space_map_first_fit_unit: match");
    end else begin
      $display("free_space_map_first_fit_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> free_space_map_first_fit_unit.f
+incdir+rtl/core
rtl/core/fsmap_pkg.sv
rtl/core/fsmap_class_ram.sv
rtl/core/fsmap_match.sv
rtl/core/fsmap_seq.sv
rtl/core/free_space_map_first_fit_unit.sv
tb/free_space_map_first_fit_unit_tb.sv
